FILE: hw/rtl/ppc_pkg.sv
// ----------------------------------------------------------------------------
// ppc_pkg
// Shared types, sizes and codes of the point-in-polygon classifier.
// ----------------------------------------------------------------------------
package ppc_pkg;

  localparam int COORD_BITS   = 16;
  localparam int MAX_VERTICES = 1024;

  // Field width on the stream and the significant bits taken from it.
  localparam int COORD_W   = 16;
  localparam int SIG_BITS  = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam int SEXT_SHIFT = COORD_W - SIG_BITS;

  // Vertex counter saturates at MAX_VERTICES + 1.
  localparam int CNT_W = $clog2(MAX_VERTICES + 2);

  localparam int EDGE_FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W      = $clog2(EDGE_FIFO_DEPTH);
  localparam int FIFO_CNT_W      = $clog2(EDGE_FIFO_DEPTH + 1);

  localparam int DIFF_W = COORD_W + 1;        // coordinate difference
  localparam int PROD_W = 2 * DIFF_W;         // difference product
  localparam int AREA_PROD_W = 2 * COORD_W;   // shoelace product
  localparam int AREA_W = 64;                 // shoelace sum, wraps
  localparam int NUM_W  = PROD_W + 1;         // crossing numerator, signed
  localparam int MAG_W  = NUM_W - 1;          // numerator magnitude
  localparam int DEN_W  = COORD_W;            // |dy| fits unsigned
  localparam int CMP_W  = MAG_W + DEN_W;      // cross-multiplied compare

  localparam int S_TDATA_W = 4 * COORD_W;
  localparam int M_TDATA_W = 8;

  localparam logic [1:0] REL_EXTERIOR = 2'd0;
  localparam logic [1:0] REL_INTERIOR = 2'd1;
  localparam logic [1:0] REL_BOUNDARY = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    coord_t qx;
    coord_t qy;
    logic   closing;   // edge back to the first vertex, ends the polygon
    logic   ovf;       // polygon exceeded MAX_VERTICES
  } edge_t;

  function automatic coord_t sext(input logic [COORD_W-1:0] v);
    logic [COORD_W-1:0] t;
    t = v << SEXT_SHIFT;
    sext = $signed(t) >>> SEXT_SHIFT;
  endfunction

endpackage

FILE: hw/rtl/point_in_polygon_classifier.sv
// ----------------------------------------------------------------------------
// point_in_polygon_classifier
// Classifies a query point against a polygon streamed one vertex per word.
// ----------------------------------------------------------------------------
// Result: registered as the edge unit ends the update step of the closing edge,
// which waits while the previous word is not yet taken. Each edge holds the
// edge unit through pop, multiply, numerator, compare and update steps.
// Throughput: words enter at one per cycle until the 4-deep edge queue fills,
// and input is held after a last vertex until its closing edge is queued.
// Reset: synchronous rst clears the queue, the front and all running sums.
module point_in_polygon_classifier (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] vertex_x, [31:16] vertex_y, [47:32] test_x, [63:48] test_y
  input  logic [63:0] s_axis_tdata,
  input  logic        s_axis_tlast,  // last_vertex
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] relation, [2] overflow, [7:3] zero
  output logic [7:0]  m_axis_tdata
);

  logic           fifo_push;
  logic           fifo_full;
  logic           fifo_pop;
  logic           fifo_empty;
  ppc_pkg::edge_t fifo_wdata;
  ppc_pkg::edge_t fifo_rdata;

  ppc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .fifo_full     (fifo_full),
    .push          (fifo_push),
    .push_data     (fifo_wdata)
  );

  ppc_edge_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (fifo_push),
    .wdata (fifo_wdata),
    .full  (fifo_full),
    .pop   (fifo_pop),
    .rdata (fifo_rdata),
    .empty (fifo_empty)
  );

  ppc_edge_unit u_edge (
    .clk           (clk),
    .rst           (rst),
    .fifo_empty    (fifo_empty),
    .fifo_rdata    (fifo_rdata),
    .pop           (fifo_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    fifo_push |-> !fifo_full)
    else $error("edge pushed into full queue");

  a_close_stall: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input taken while closing edge pending");

  a_rel_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[1:0] == ppc_pkg::REL_EXTERIOR ||
                       m_axis_tdata[1:0] == ppc_pkg::REL_INTERIOR ||
                       m_axis_tdata[1:0] == ppc_pkg::REL_BOUNDARY))
    else $error("invalid relation code");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    fifo_pop |-> !fifo_empty)
    else $error("edge popped from empty queue");
`endif

endmodule

FILE: hw/rtl/ppc_edge_fifo.sv
// ----------------------------------------------------------------------------
// ppc_edge_fifo
// Short queue of polygon edges between the front and the edge unit.
// ----------------------------------------------------------------------------
module ppc_edge_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ppc_pkg::edge_t wdata,
  output logic          full,
  input  logic          pop,
  output ppc_pkg::edge_t rdata,
  output logic          empty
);

  ppc_pkg::edge_t                   mem [ppc_pkg::EDGE_FIFO_DEPTH];
  logic [ppc_pkg::FIFO_PTR_W-1:0]   wr_ptr;
  logic [ppc_pkg::FIFO_PTR_W-1:0]   rd_ptr;
  logic [ppc_pkg::FIFO_CNT_W-1:0]   count;

  assign full  = (count == ppc_pkg::FIFO_CNT_W'(ppc_pkg::EDGE_FIFO_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/ppc_front.sv
// ----------------------------------------------------------------------------
// ppc_front
// Takes vertex words, tracks first and previous vertex, emits edges.
// ----------------------------------------------------------------------------
module ppc_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [ppc_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  input  logic                            s_axis_tlast,
  input  logic                            fifo_full,
  output logic                            push,
  output ppc_pkg::edge_t                  push_data
);

  logic                        started;
  ppc_pkg::coord_t             first_x;
  ppc_pkg::coord_t             first_y;
  ppc_pkg::coord_t             prev_x;
  ppc_pkg::coord_t             prev_y;
  ppc_pkg::coord_t             query_x;
  ppc_pkg::coord_t             query_y;
  logic [ppc_pkg::CNT_W-1:0]   count;
  logic [ppc_pkg::CNT_W-1:0]   count_next;
  logic                        pend;
  ppc_pkg::edge_t              pend_edge;

  ppc_pkg::coord_t vx;
  ppc_pkg::coord_t vy;
  ppc_pkg::coord_t tx;
  ppc_pkg::coord_t ty;
  logic            take;

  assign vx = ppc_pkg::sext(s_axis_tdata[15:0]);
  assign vy = ppc_pkg::sext(s_axis_tdata[31:16]);
  assign tx = ppc_pkg::sext(s_axis_tdata[47:32]);
  assign ty = ppc_pkg::sext(s_axis_tdata[63:48]);

  // Hold input while the closing edge waits for queue space or the queue is full.
  assign s_axis_tready = !pend && !fifo_full;
  assign take          = s_axis_tvalid && s_axis_tready;

  assign count_next = (count <= ppc_pkg::CNT_W'(ppc_pkg::MAX_VERTICES)) ?
                      count + 1'b1 : count;

  always_comb begin
    if (pend) begin
      push      = !fifo_full;
      push_data = pend_edge;
    end else begin
      push              = take && started;
      push_data.sx      = prev_x;
      push_data.sy      = prev_y;
      push_data.ex      = vx;
      push_data.ey      = vy;
      push_data.qx      = query_x;
      push_data.qy      = query_y;
      push_data.closing = 1'b0;
      push_data.ovf     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && s_axis_tlast) begin
      pend_edge.sx      <= vx;
      pend_edge.sy      <= vy;
      pend_edge.ex      <= started ? first_x : vx;
      pend_edge.ey      <= started ? first_y : vy;
      pend_edge.qx      <= started ? query_x : tx;
      pend_edge.qy      <= started ? query_y : ty;
      pend_edge.closing <= 1'b1;
      pend_edge.ovf     <= (count_next > ppc_pkg::CNT_W'(ppc_pkg::MAX_VERTICES));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      first_x <= '0;
      first_y <= '0;
      prev_x  <= '0;
      prev_y  <= '0;
      query_x <= '0;
      query_y <= '0;
      count   <= '0;
      pend    <= 1'b0;
    end else begin
      if (pend && !fifo_full) begin
        pend <= 1'b0;
      end
      if (take) begin
        if (s_axis_tlast) begin
          // Queue the closing edge once there is space and start a fresh polygon.
          pend    <= 1'b1;
          started <= 1'b0;
          count   <= '0;
        end else begin
          if (!started) begin
            started <= 1'b1;
            first_x <= vx;
            first_y <= vy;
            query_x <= tx;
            query_y <= ty;
          end
          prev_x <= vx;
          prev_y <= vy;
          count  <= count_next;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/ppc_edge_unit.sv
// ----------------------------------------------------------------------------
// ppc_edge_unit
// Works through queued edges: crossing test, nearest-crossing compare and
// shoelace sum; drives the result word at the closing edge.
// ----------------------------------------------------------------------------
module ppc_edge_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            fifo_empty,
  input  ppc_pkg::edge_t                  fifo_rdata,
  output logic                            pop,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [ppc_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_NUM  = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_UPD  = 3'd4;

  logic [2:0]     state;
  logic [2:0]     state_next;
  ppc_pkg::edge_t cur;

  // Stage registers.
  logic signed [ppc_pkg::PROD_W-1:0]      p1;
  logic signed [ppc_pkg::PROD_W-1:0]      p2;
  logic signed [ppc_pkg::AREA_PROD_W-1:0] a1;
  logic signed [ppc_pkg::AREA_PROD_W-1:0] a2;
  logic                                   horiz;
  logic                                   horiz_hit;
  logic                                   span;
  logic                                   up;
  logic [ppc_pkg::DEN_W-1:0]              den;
  logic signed [ppc_pkg::NUM_W-1:0]       num;
  logic [ppc_pkg::CMP_W-1:0]              c1;
  logic [ppc_pkg::CMP_W-1:0]              c2;

  // Running polygon state.
  logic [ppc_pkg::AREA_W-1:0] area_sum;
  logic                       have_best;
  logic [ppc_pkg::MAG_W-1:0]  best_num;
  logic [ppc_pkg::DEN_W-1:0]  best_den;
  logic                       best_upward;
  logic                       hit_boundary;

  logic                      out_valid;
  logic [1:0]                out_rel;
  logic                      out_ovf;

  logic signed [ppc_pkg::DIFF_W-1:0] yl;
  logic signed [ppc_pkg::DIFF_W-1:0] yo;
  logic signed [ppc_pkg::DIFF_W-1:0] dxq;
  logic signed [ppc_pkg::DIFF_W-1:0] dxe;
  logic signed [ppc_pkg::DIFF_W-1:0] yl_abs;
  logic signed [ppc_pkg::NUM_W-1:0]  diff;
  logic signed [ppc_pkg::AREA_PROD_W:0] aterm;

  logic       out_free;
  logic       advance;
  logic       num_zero;
  logic       hit_next;
  logic       better;
  logic       have_next;
  logic       up_next;
  logic [1:0] rel_next;

  assign yl  = $signed({cur.ey[15], cur.ey}) - $signed({cur.sy[15], cur.sy});
  assign yo  = $signed({cur.qy[15], cur.qy}) - $signed({cur.sy[15], cur.sy});
  assign dxq = $signed({cur.qx[15], cur.qx}) - $signed({cur.sx[15], cur.sx});
  assign dxe = $signed({cur.ex[15], cur.ex}) - $signed({cur.sx[15], cur.sx});
  assign yl_abs = (yl < 0) ? -yl : yl;

  assign diff  = $signed({p1[ppc_pkg::PROD_W-1], p1})
               - $signed({p2[ppc_pkg::PROD_W-1], p2});
  assign aterm = $signed({a1[ppc_pkg::AREA_PROD_W-1], a1})
               - $signed({a2[ppc_pkg::AREA_PROD_W-1], a2});

  assign out_free = !out_valid || m_axis_tready;
  assign advance  = !cur.closing || out_free;
  assign pop      = (state == ST_IDLE) && !fifo_empty;

  assign num_zero  = (num == '0);
  assign hit_next  = hit_boundary || (horiz ? horiz_hit : (span && num_zero));
  assign better    = !horiz && span && !num[ppc_pkg::NUM_W-1] && !num_zero &&
                     (!have_best || (c1 < c2));
  assign have_next = have_best || better;
  assign up_next   = better ? up : best_upward;

  always_comb begin
    if (hit_next) begin
      rel_next = ppc_pkg::REL_BOUNDARY;
    end else if (have_next ? up_next : area_sum[ppc_pkg::AREA_W-1]) begin
      rel_next = ppc_pkg::REL_INTERIOR;
    end else begin
      rel_next = ppc_pkg::REL_EXTERIOR;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (!fifo_empty) state_next = ST_MUL;
      ST_MUL:  state_next = ST_NUM;
      ST_NUM:  state_next = ST_CMP;
      ST_CMP:  state_next = ST_UPD;
      ST_UPD:  if (advance) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= fifo_rdata;
    end
    if (state == ST_MUL) begin
      p1        <= dxq * yl;
      p2        <= dxe * yo;
      a1        <= cur.sx * cur.ey;
      a2        <= cur.ex * cur.sy;
      horiz     <= (yl == '0);
      horiz_hit <= (yo == '0) &&
                   ((cur.sx <= cur.qx && cur.qx <= cur.ex) ||
                    (cur.sx >= cur.qx && cur.qx >= cur.ex));
      span      <= (yl > 0) ? (yo >= 0 && yo <= yl) : (yo <= 0 && yo >= yl);
      up        <= (yl > 0);
      den       <= yl_abs[ppc_pkg::DEN_W-1:0];
    end
    if (state == ST_NUM) begin
      num <= up ? diff : -diff;
    end
    if (state == ST_CMP) begin
      c1 <= num[ppc_pkg::MAG_W-1:0] * best_den;
      c2 <= best_num * den;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      area_sum     <= '0;
      have_best    <= 1'b0;
      best_num     <= '0;
      best_den     <= '0;
      best_upward  <= 1'b0;
      hit_boundary <= 1'b0;
      out_valid    <= 1'b0;
      out_rel      <= ppc_pkg::REL_EXTERIOR;
      out_ovf      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_UPD && advance && cur.closing) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (state == ST_NUM) begin
        area_sum <= area_sum +
                    {{(ppc_pkg::AREA_W - ppc_pkg::AREA_PROD_W - 1){aterm[ppc_pkg::AREA_PROD_W]}},
                     aterm};
      end
      if (state == ST_UPD && advance) begin
        if (cur.closing) begin
          // Emit the word and clear for the next polygon.
          out_rel      <= rel_next;
          out_ovf      <= cur.ovf;
          area_sum     <= '0;
          have_best    <= 1'b0;
          best_num     <= '0;
          best_den     <= '0;
          best_upward  <= 1'b0;
          hit_boundary <= 1'b0;
        end else begin
          hit_boundary <= hit_next;
          if (better) begin
            have_best   <= 1'b1;
            best_num    <= num[ppc_pkg::MAG_W-1:0];
            best_den    <= den;
            best_upward <= up;
          end
        end
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(ppc_pkg::M_TDATA_W - 3){1'b0}}, out_ovf, out_rel};

endmodule
